@@ rtl/bcsc_pkg.sv @@
// Shared types, register map and coefficient helper for the BT.601 colour space converter.
// Used by bcsc_csr, bcsc_dot3 and bt601_colour_space_converter; no dependencies.
package bcsc_pkg;

   // Default fraction bits of the fixed-point coefficients
   localparam int FRAC_BITS_DEFAULT = 16;

   // Sample and operand widths
   localparam int SAMPLE_W = 8;
   localparam int OPND_W   = SAMPLE_W + 1;
   localparam int DATA_W   = 4 * SAMPLE_W;

   // Register map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MODE = 2'd0;

   // Conversion direction
   typedef enum logic {
      MODE_YUV2RGB = 1'b0,
      MODE_RGB2YUV = 1'b1
   } mode_type;

   // Stage enables handed to each dot-product lane
   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } stage_ctl_type;

   // Coefficient given in thousandths, rounded half up to frac fraction bits
   function automatic longint coef_fix(input longint milli, input int frac);
      return ((milli <<< frac) + 64'sd500) / 64'sd1000;
   endfunction

endpackage

@@ rtl/bcsc_csr.sv @@
// Configuration register file (APB-style) holding the conversion mode.
// Depends on bcsc_pkg.
module bcsc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bcsc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bcsc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bcsc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output bcsc_pkg::mode_type                   mode
);

   bcsc_pkg::mode_type mode_ff;
   bcsc_pkg::mode_type mode_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Keep bit 0 of a mode write, drop writes to other addresses
   always_comb begin
      mode_in = mode_ff;
      if (wr_en && (csr_paddr == bcsc_pkg::ADDR_MODE)) begin
         mode_in = bcsc_pkg::mode_type'(csr_pwdata[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bcsc_pkg::MODE_YUV2RGB;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == bcsc_pkg::ADDR_MODE) begin
         csr_prdata[0] = mode_ff;
      end
   end

   assign mode = mode_ff;

endmodule

@@ rtl/bcsc_dot3.sv @@
// One output lane: three registered signed products, then a registered sum with offset.
// Depends on bcsc_pkg.
module bcsc_dot3 #(
   parameter int FRAC_BITS = bcsc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  bcsc_pkg::stage_ctl_type                   ctl,
   input  logic signed [bcsc_pkg::OPND_W-1:0]        opnd [3],
   input  logic signed [FRAC_BITS+2:0]               coef [3],
   input  logic signed [FRAC_BITS+bcsc_pkg::OPND_W+4:0] ofs,
   output logic signed [FRAC_BITS+bcsc_pkg::OPND_W+4:0] sum
);

   localparam int CW = FRAC_BITS + 3;
   localparam int PW = CW + bcsc_pkg::OPND_W;
   localparam int SW = PW + 2;

   logic signed [PW-1:0] prod_in [3];
   logic signed [PW-1:0] prod_ff [3];
   logic signed [SW-1:0] sum_in;
   logic signed [SW-1:0] sum_ff;

   // Multiply each operand by its coefficient
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = PW'(opnd[i]) * PW'(coef[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Add the three products and the offset
   assign sum_in = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]) + ofs;

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

@@ rtl/bt601_colour_space_converter.sv @@
// BT.601 studio-range YCbCr <-> 8-bit RGB converter, top level.
// Depends on bcsc_pkg, bcsc_csr and bcsc_dot3.
//
// Usage:
//   req_* takes one pixel per transfer: three colour components and alpha.
//   rsp_* returns one converted pixel per input pixel, in order; alpha is copied.
//   csr_* is an APB-style port; register 0 (address 0) holds the mode:
//   0 converts YCbCr to RGB, 1 converts RGB to YCbCr. Write it only while idle.
// Timing:
//   Four register stages: operand capture, multiply, sum, floor and clamp.
//   A pixel accepted into operand capture passes through the multiply, sum
//   and floor-and-clamp registers to rsp_*. One pixel per clock is sustained
//   while rsp_tready is high; multiply uses three lanes of three multipliers.
// Reset:
//   Synchronous reset empties the pipeline and sets the mode to 0.
// Stall:
//   When rsp_tready is low the result is held; earlier stages keep filling
//   until every stage holds a pixel, and only then does req_tready drop.
module bt601_colour_space_converter #(
   parameter int FRAC_BITS = bcsc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // comp_a [7:0], comp_b [15:8], comp_c [23:16], alpha_in [31:24]
   input  logic [bcsc_pkg::DATA_W-1:0]          req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // res_a [7:0], res_b [15:8], res_c [23:16], alpha_out [31:24]
   output logic [bcsc_pkg::DATA_W-1:0]          rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bcsc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bcsc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bcsc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int SMW = bcsc_pkg::SAMPLE_W;
   localparam int XW  = bcsc_pkg::OPND_W;
   localparam int CW  = FRAC_BITS + 3;
   localparam int SW  = CW + XW + 2;
   localparam int VW  = SW - FRAC_BITS;

   // Coefficients
   localparam logic signed [CW-1:0] K_ZERO  = '0;
   localparam logic signed [CW-1:0] K_1164  = CW'(bcsc_pkg::coef_fix(1164, FRAC_BITS));
   localparam logic signed [CW-1:0] K_1596  = CW'(bcsc_pkg::coef_fix(1596, FRAC_BITS));
   localparam logic signed [CW-1:0] K_N813  = CW'(-bcsc_pkg::coef_fix(813, FRAC_BITS));
   localparam logic signed [CW-1:0] K_N391  = CW'(-bcsc_pkg::coef_fix(391, FRAC_BITS));
   localparam logic signed [CW-1:0] K_2018  = CW'(bcsc_pkg::coef_fix(2018, FRAC_BITS));
   localparam logic signed [CW-1:0] K_257   = CW'(bcsc_pkg::coef_fix(257, FRAC_BITS));
   localparam logic signed [CW-1:0] K_504   = CW'(bcsc_pkg::coef_fix(504, FRAC_BITS));
   localparam logic signed [CW-1:0] K_98    = CW'(bcsc_pkg::coef_fix(98, FRAC_BITS));
   localparam logic signed [CW-1:0] K_N148  = CW'(-bcsc_pkg::coef_fix(148, FRAC_BITS));
   localparam logic signed [CW-1:0] K_N291  = CW'(-bcsc_pkg::coef_fix(291, FRAC_BITS));
   localparam logic signed [CW-1:0] K_439   = CW'(bcsc_pkg::coef_fix(439, FRAC_BITS));
   localparam logic signed [CW-1:0] K_N368  = CW'(-bcsc_pkg::coef_fix(368, FRAC_BITS));
   localparam logic signed [CW-1:0] K_N71   = CW'(-bcsc_pkg::coef_fix(71, FRAC_BITS));

   // Offsets for the RGB to YCbCr direction
   localparam logic signed [SW-1:0] OFS_ZERO = '0;
   localparam logic signed [SW-1:0] OFS_16   = SW'(longint'(16) <<< FRAC_BITS);
   localparam logic signed [SW-1:0] OFS_128  = SW'(longint'(128) <<< FRAC_BITS);

   bcsc_pkg::mode_type mode;

   // Stage valids and per-stage advance
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic v0_in, v1_in, v2_in, v3_in;
   logic rdy0, rdy1, rdy2, rdy3;
   bcsc_pkg::stage_ctl_type ctl;

   // Stage payloads
   logic signed [XW-1:0]  s0_opnd_ff [3];
   logic signed [XW-1:0]  s0_opnd_in [3];
   bcsc_pkg::mode_type    s0_mode_ff, s1_mode_ff, s2_mode_ff, s3_mode_ff;
   logic [SMW-1:0]        s0_alpha_ff, s1_alpha_ff, s2_alpha_ff, s3_alpha_ff;
   logic [SMW-1:0]        s3_res_ff [3];
   logic [SMW-1:0]        s3_res_in [3];

   logic signed [CW-1:0]  coef_a [3];
   logic signed [CW-1:0]  coef_b [3];
   logic signed [CW-1:0]  coef_c [3];
   logic signed [SW-1:0]  ofs_a, ofs_b, ofs_c;
   logic signed [SW-1:0]  sum [3];

   logic [SMW-1:0] comp_a, comp_b, comp_c, alpha_in;

   bcsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mode        (mode)
   );

   // Unpack the input transfer
   assign comp_a   = req_tdata[SMW-1:0];
   assign comp_b   = req_tdata[2*SMW-1:SMW];
   assign comp_c   = req_tdata[3*SMW-1:2*SMW];
   assign alpha_in = req_tdata[4*SMW-1:3*SMW];

   // Each stage advances when it is empty or the next stage advances
   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign rdy0       = !v0_ff || rdy1;
   assign req_tready = rdy0 && !reset;
   assign ctl.mul_en = rdy1;
   assign ctl.sum_en = rdy2;

   assign v0_in = rdy0 ? (req_tvalid && req_tready) : v0_ff;
   assign v1_in = rdy1 ? v0_ff : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage 0: remove the YCbCr offsets, or take RGB as is
   always_comb begin
      case (mode)
         bcsc_pkg::MODE_YUV2RGB: begin
            s0_opnd_in[0] = {1'b0, comp_a} - XW'(16);
            s0_opnd_in[1] = {1'b0, comp_b} - XW'(128);
            s0_opnd_in[2] = {1'b0, comp_c} - XW'(128);
         end
         default: begin
            s0_opnd_in[0] = {1'b0, comp_a};
            s0_opnd_in[1] = {1'b0, comp_b};
            s0_opnd_in[2] = {1'b0, comp_c};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         s0_opnd_ff  <= s0_opnd_in;
         s0_mode_ff  <= mode;
         s0_alpha_ff <= alpha_in;
      end
   end

   // Pick the coefficient set for the pixel in stage 0
   always_comb begin
      case (s0_mode_ff)
         bcsc_pkg::MODE_YUV2RGB: begin
            coef_a = '{K_1164, K_ZERO, K_1596};
            coef_b = '{K_1164, K_N391, K_N813};
            coef_c = '{K_1164, K_2018, K_ZERO};
         end
         default: begin
            coef_a = '{K_257, K_504, K_98};
            coef_b = '{K_N148, K_N291, K_439};
            coef_c = '{K_439, K_N368, K_N71};
         end
      endcase
   end

   // Pick the offsets for the pixel in stage 1
   always_comb begin
      case (s1_mode_ff)
         bcsc_pkg::MODE_YUV2RGB: begin
            ofs_a = OFS_ZERO;
            ofs_b = OFS_ZERO;
            ofs_c = OFS_ZERO;
         end
         default: begin
            ofs_a = OFS_16;
            ofs_b = OFS_128;
            ofs_c = OFS_128;
         end
      endcase
   end

   // Stages 1 and 2 sideband
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_mode_ff  <= s0_mode_ff;
         s1_alpha_ff <= s0_alpha_ff;
      end
      if (rdy2) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_alpha_ff <= s1_alpha_ff;
      end
   end

   bcsc_dot3 #(.FRAC_BITS(FRAC_BITS)) u_dot_a (
      .clock (clock),
      .ctl   (ctl),
      .opnd  (s0_opnd_ff),
      .coef  (coef_a),
      .ofs   (ofs_a),
      .sum   (sum[0])
   );

   bcsc_dot3 #(.FRAC_BITS(FRAC_BITS)) u_dot_b (
      .clock (clock),
      .ctl   (ctl),
      .opnd  (s0_opnd_ff),
      .coef  (coef_b),
      .ofs   (ofs_b),
      .sum   (sum[1])
   );

   bcsc_dot3 #(.FRAC_BITS(FRAC_BITS)) u_dot_c (
      .clock (clock),
      .ctl   (ctl),
      .opnd  (s0_opnd_ff),
      .coef  (coef_c),
      .ofs   (ofs_c),
      .sum   (sum[2])
   );

   // Stage 3: floor to an integer and clamp to 0..255
   always_comb begin
      logic [VW-1:0] whole;
      for (int i = 0; i < 3; i++) begin
         whole = sum[i][SW-1:FRAC_BITS];
         if (whole[VW-1]) begin
            s3_res_in[i] = '0;
         end else if (whole[VW-2:SMW] != '0) begin
            s3_res_in[i] = '1;
         end else begin
            s3_res_in[i] = whole[SMW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_res_ff   <= s3_res_in;
         s3_mode_ff  <= s2_mode_ff;
         s3_alpha_ff <= s2_alpha_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {s3_alpha_ff, s3_res_ff[2], s3_res_ff[1], s3_res_ff[0]};

   // A pixel with a free-flowing output reaches rsp_* with its alpha unchanged
   a_alpha_latency: assert property (@(posedge clock) disable iff (reset)
      ($past(req_tvalid && req_tready, 4) && $past(rsp_tready, 1) && $past(rsp_tready, 2)
       && $past(rsp_tready, 3) && !$past(reset, 1) && !$past(reset, 2)
       && !$past(reset, 3) && !$past(reset, 4))
      |-> (rsp_tvalid && (rsp_tdata[31:24] == $past(req_tdata[31:24], 4))))
      else $error("pixel lost or alpha changed in the pipeline");

   // RGB to YCbCr results never need the clamp
   a_yuv_range: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && (s3_mode_ff == bcsc_pkg::MODE_RGB2YUV))
      |-> ((s3_res_ff[0] >= 8'd16) && (s3_res_ff[0] <= 8'd240)
           && (s3_res_ff[1] >= 8'd16) && (s3_res_ff[1] <= 8'd240)
           && (s3_res_ff[2] >= 8'd16) && (s3_res_ff[2] <= 8'd240)))
      else $error("RGB to YCbCr result outside 16..240");

   // Input stalls only when every stage is full and the output is blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      (!req_tready) |-> (v0_ff && v1_ff && v2_ff && v3_ff && !rsp_tready))
      else $error("input stalled while the pipeline has a bubble");

endmodule
